// ===== rtl/core/hpa_pkg.sv =====
// Package for the handle pool allocator: request and status codes, sequencer states
// and the fixed handle geometry. Used by the top level, the sequencer and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package hpa_pkg;

   localparam int HANDLE_W          = 8;
   localparam int SLOTS             = 1 << HANDLE_W;
   localparam int POOL_SIZE_DEFAULT = 256;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_TRY     = 2'd1,
      OP_RELEASE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NONE      = 2'd1,
      STAT_INVALID   = 2'd2,
      STAT_EXHAUSTED = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/fifo_handle_pool_allocator_top.sv =====
// Top level of the handle pool allocator: sequencer plus in-use and free-queue RAMs.
// Depends on hpa_pkg, hpa_ram and hpa_ctrl.
//
//   Channel   Direction  Handshake            Payload
//   request   in         start & !busy        req_op, req_handle
//   response  out        rsp_valid (1 cycle)  rsp_granted_handle, rsp_status
//
// A request is accepted at an edge that reads both RAMs; the execute state then
// updates them, and busy holds off a new request until the sequencer is idle again.
// The response is registered and appears in the cycle after the execute cycle.
// Reset is synchronous; no clearing pass is needed since the mint counter marks
// which in-use entries were ever written. The receiver cannot stall responses.
`timescale 1ns / 1ps
`default_nettype none

module fifo_handle_pool_allocator_top
   import hpa_pkg::*;
#(
   parameter int POOL_SIZE  = POOL_SIZE_DEFAULT,
   localparam int MINT_LIMIT = (POOL_SIZE > SLOTS) ? SLOTS : POOL_SIZE,
   localparam int IDX_W      = $clog2(MINT_LIMIT)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [1:0]          req_op,
   input  wire logic [HANDLE_W-1:0] req_handle,
   output logic                     rsp_valid,
   output logic [HANDLE_W-1:0]      rsp_granted_handle,
   output logic [1:0]               rsp_status
);

   logic                use_rd_en;
   logic [IDX_W-1:0]    use_rd_addr;
   logic                use_rd_data;
   logic                use_wr_en;
   logic [IDX_W-1:0]    use_wr_addr;
   logic                use_wr_data;
   logic                que_rd_en;
   logic [IDX_W-1:0]    que_rd_addr;
   logic [HANDLE_W-1:0] que_rd_data;
   logic                que_wr_en;
   logic [IDX_W-1:0]    que_wr_addr;
   logic [HANDLE_W-1:0] que_wr_data;

   hpa_ctrl #(
      .MINT_LIMIT (MINT_LIMIT)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_handle         (req_handle),
      .rsp_valid          (rsp_valid),
      .rsp_granted_handle (rsp_granted_handle),
      .rsp_status         (rsp_status),
      .use_rd_en          (use_rd_en),
      .use_rd_addr        (use_rd_addr),
      .use_rd_data        (use_rd_data),
      .use_wr_en          (use_wr_en),
      .use_wr_addr        (use_wr_addr),
      .use_wr_data        (use_wr_data),
      .que_rd_en          (que_rd_en),
      .que_rd_addr        (que_rd_addr),
      .que_rd_data        (que_rd_data),
      .que_wr_en          (que_wr_en),
      .que_wr_addr        (que_wr_addr),
      .que_wr_data        (que_wr_data)
   );

   hpa_ram #(
      .WIDTH (1),
      .DEPTH (MINT_LIMIT)
   ) u_use_ram (
      .clock   (clock),
      .rd_en   (use_rd_en),
      .rd_addr (use_rd_addr),
      .rd_data (use_rd_data),
      .wr_en   (use_wr_en),
      .wr_addr (use_wr_addr),
      .wr_data (use_wr_data)
   );

   hpa_ram #(
      .WIDTH (HANDLE_W),
      .DEPTH (MINT_LIMIT)
   ) u_que_ram (
      .clock   (clock),
      .rd_en   (que_rd_en),
      .rd_addr (que_rd_addr),
      .rd_data (que_rd_data),
      .wr_en   (que_wr_en),
      .wr_addr (que_wr_addr),
      .wr_data (que_wr_data)
   );

endmodule

`default_nettype wire

// ===== rtl/core/hpa_ram.sv =====
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Standalone; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data is registered and holds until the next read, so the sequencer can use it in the cycle after the read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hpa_ctrl.sv =====
// Request sequencer of the handle pool allocator: queue pointers, mint counter and the
// read-modify-write of the in-use and free-queue RAMs. Depends on hpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpa_ctrl
   import hpa_pkg::*;
#(
   parameter int MINT_LIMIT = SLOTS,
   localparam int IDX_W     = $clog2(MINT_LIMIT),
   localparam int CNT_W     = $clog2(MINT_LIMIT + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [1:0]          req_op,
   input  wire logic [HANDLE_W-1:0] req_handle,
   output logic                     rsp_valid,
   output logic [HANDLE_W-1:0]      rsp_granted_handle,
   output logic [1:0]               rsp_status,
   // In-use bit RAM
   output logic                     use_rd_en,
   output logic [IDX_W-1:0]         use_rd_addr,
   input  wire logic                use_rd_data,
   output logic                     use_wr_en,
   output logic [IDX_W-1:0]         use_wr_addr,
   output logic                     use_wr_data,
   // Free-queue RAM
   output logic                     que_rd_en,
   output logic [IDX_W-1:0]         que_rd_addr,
   input  wire logic [HANDLE_W-1:0] que_rd_data,
   output logic                     que_wr_en,
   output logic [IDX_W-1:0]         que_wr_addr,
   output logic [HANDLE_W-1:0]      que_wr_data
);

   state_type            state_ff, state_in;
   logic [1:0]           op_ff;
   logic [HANDLE_W-1:0]  handle_ff;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]     qcount_ff, qcount_in;
   logic [CNT_W-1:0]     fresh_ff, fresh_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0]  rsp_handle_ff, rsp_handle_in;
   status_type           rsp_status_ff, rsp_status_in;

   logic                 accept;
   logic                 queue_nonempty;
   logic                 can_mint;
   logic                 handle_minted;
   logic                 handle_in_use;
   logic [IDX_W-1:0]     head_next;
   logic [IDX_W-1:0]     tail_next;

   assign accept = start && (state_ff == S_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      case (state_ff)
         S_IDLE:  busy = 1'b0;
         S_EXEC:  busy = 1'b1;
         default: busy = 1'b1;
      endcase
   end

   // Both RAMs are read at the accept edge; the data is ready in the execute cycle.
   assign use_rd_en   = accept;
   assign use_rd_addr = req_handle[IDX_W-1:0];
   assign que_rd_en   = accept;
   assign que_rd_addr = head_ff;

   assign queue_nonempty = (qcount_ff != '0);
   assign can_mint       = (fresh_ff != CNT_W'(MINT_LIMIT));
   // Handles at or above the mint counter were never written into the in-use RAM.
   assign handle_minted  = (9'(handle_ff) < 9'(fresh_ff));
   assign handle_in_use  = handle_minted && use_rd_data;

   assign head_next = (head_ff == IDX_W'(MINT_LIMIT - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == IDX_W'(MINT_LIMIT - 1)) ? '0 : tail_ff + 1'b1;

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      qcount_in     = qcount_ff;
      fresh_in      = fresh_ff;
      rsp_valid_in  = 1'b0;
      rsp_handle_in = '0;
      rsp_status_in = STAT_OK;
      use_wr_en     = 1'b0;
      use_wr_addr   = fresh_ff[IDX_W-1:0];
      use_wr_data   = 1'b0;
      que_wr_en     = 1'b0;
      que_wr_addr   = tail_ff;
      que_wr_data   = handle_ff;
      if (state_ff == S_EXEC) begin
         rsp_valid_in = 1'b1;
         case (op_ff)
            OP_ALLOC, OP_TRY: begin
               if (queue_nonempty) begin
                  rsp_handle_in = que_rd_data;
                  head_in       = head_next;
                  qcount_in     = qcount_ff - 1'b1;
                  use_wr_en     = 1'b1;
                  use_wr_addr   = que_rd_data[IDX_W-1:0];
                  use_wr_data   = 1'b1;
               end else if (op_ff == OP_TRY) begin
                  rsp_status_in = STAT_NONE;
               end else if (can_mint) begin
                  rsp_handle_in = HANDLE_W'(fresh_ff);
                  fresh_in      = fresh_ff + 1'b1;
                  use_wr_en     = 1'b1;
                  use_wr_data   = 1'b1;
               end else begin
                  rsp_status_in = STAT_EXHAUSTED;
               end
            end
            OP_RELEASE: begin
               if (!handle_in_use || qcount_ff == CNT_W'(MINT_LIMIT)) begin
                  rsp_status_in = STAT_INVALID;
               end else begin
                  use_wr_en   = 1'b1;
                  use_wr_addr = handle_ff[IDX_W-1:0];
                  que_wr_en   = 1'b1;
                  tail_in     = tail_next;
                  qcount_in   = qcount_ff + 1'b1;
               end
            end
            default: begin
               rsp_status_in = STAT_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         qcount_ff    <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         qcount_ff    <= qcount_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_op;
         handle_ff <= req_handle;
      end
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted_handle = rsp_handle_ff;
   assign rsp_status         = rsp_status_ff;

`ifndef SYNTHESIS
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_EXEC))
      else $error("response without an executed request");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted request did not reach execute");

   a_queue_le_minted: assert property (@(posedge clock) disable iff (reset)
      qcount_ff <= fresh_ff)
      else $error("free queue holds more handles than were minted");

   a_fresh_limit: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= CNT_W'(MINT_LIMIT))
      else $error("mint counter past the pool size");

   a_exhausted_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STAT_EXHAUSTED) |->
         (qcount_ff == '0 && fresh_ff == CNT_W'(MINT_LIMIT)))
      else $error("exhaustion reported with handles still available");
`endif

endmodule

`default_nettype wire

// ===== sim/fifo_handle_pool_allocator_top_tb.sv =====
// Self-checking testbench for fifo_handle_pool_allocator_top: directed and random requests
// against a behavioral model of the handle pool. Depends on hpa_pkg and the block's RTL.
`timescale 1ns / 1ps

module fifo_handle_pool_allocator_top_tb;
   import hpa_pkg::*;

   localparam int MINT_LIMIT = (POOL_SIZE_DEFAULT > SLOTS) ? SLOTS : POOL_SIZE_DEFAULT;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 1000;

   typedef struct {
      logic [HANDLE_W-1:0] granted;
      status_type          status;
   } pool_response_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_op;
   logic [HANDLE_W-1:0] req_handle;
   logic                rsp_valid;
   logic [HANDLE_W-1:0] rsp_granted_handle;
   logic [1:0]          rsp_status;

   // Behavioral copy of the pool state.
   bit                  handle_held [SLOTS];
   logic [HANDLE_W-1:0] released_fifo [$];
   int unsigned         minted_count = 0;

   pool_response_type awaited_responses [$];
   int unsigned    max_gap = 7;
   int unsigned    sent_count = 0;
   int unsigned    fail_count = 0;
   int unsigned    idle_cycles = 0;
   int unsigned    status_seen [4] = '{0, 0, 0, 0};

   fifo_handle_pool_allocator_top DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_handle         (req_handle),
      .rsp_valid          (rsp_valid),
      .rsp_granted_handle (rsp_granted_handle),
      .rsp_status         (rsp_status)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic pool_response_type predict_response(input logic [1:0] op,
                                                          input logic [HANDLE_W-1:0] handle);
      pool_response_type r;
      r.granted = '0;
      r.status  = STAT_OK;
      case (op)
         OP_ALLOC, OP_TRY: begin
            if (released_fifo.size() != 0) begin
               r.granted = released_fifo.pop_front();
               handle_held[r.granted] = 1'b1;
            end else if (op == OP_TRY) begin
               r.status = STAT_NONE;
            end else if (minted_count < MINT_LIMIT) begin
               r.granted = minted_count[HANDLE_W-1:0];
               handle_held[r.granted] = 1'b1;
               minted_count++;
            end else begin
               r.status = STAT_EXHAUSTED;
            end
         end
         OP_RELEASE: begin
            if (!handle_held[handle] || released_fifo.size() >= SLOTS) begin
               r.status = STAT_INVALID;
            end else begin
               handle_held[handle] = 1'b0;
               released_fifo.push_back(handle);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Returns at the edge that accepted the request, with start still high.
   task automatic send_request(input logic [1:0] op, input logic [HANDLE_W-1:0] handle);
      int unsigned gap;
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_op     <= op;
      req_handle <= handle;
      do @(posedge clock); while (busy);
      awaited_responses.push_back(predict_response(op, handle));
      sent_count++;
   endtask

   task automatic test_directed_cases;
      send_request(OP_TRY, 8'h00);        // empty queue on try allocate
      send_request(OP_ALLOC, 8'hFF);      // fresh handle 0, handle field ignored
      send_request(OP_RELEASE, 8'hFF);    // never minted
      send_request(OP_RELEASE, 8'h00);
      send_request(OP_RELEASE, 8'h00);    // already released
      send_request(OP_UNUSED, 8'h00);
      send_request(OP_UNUSED, 8'hFF);
      send_request(OP_ALLOC, 8'h00);      // comes back from the queue
      send_request(OP_ALLOC, 8'h55);
      send_request(OP_ALLOC, 8'hAA);
      send_request(OP_RELEASE, 8'h02);
      send_request(OP_RELEASE, 8'h01);
      send_request(OP_TRY, 8'hFF);        // oldest released first
      send_request(OP_ALLOC, 8'h00);
      send_request(OP_ALLOC, 8'h00);
      send_request(OP_RELEASE, 8'h00);
      send_request(OP_RELEASE, 8'h03);
      send_request(OP_RELEASE, 8'h01);
      send_request(OP_ALLOC, 8'h00);
      send_request(OP_TRY, 8'h00);
      send_request(OP_TRY, 8'h00);
      send_request(OP_TRY, 8'h00);
   endtask

   task automatic test_mixed_traffic(input int unsigned count);
      int unsigned alloc_pct;
      int unsigned pick;
      int unsigned first;
      logic [HANDLE_W-1:0] handle;
      logic [HANDLE_W-1:0] cand;
      bit found;
      for (int unsigned n = 0; n < count; n++) begin
         // Every 40 requests, change the alloc/release balance and the idling style
         // so the queue alternately fills up and runs dry.
         if (n % 40 == 0) begin
            alloc_pct = 10 + 20 * $urandom_range(0, 4);
            max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 7;
         end
         handle = HANDLE_W'($urandom_range(0, SLOTS - 1));
         pick   = $urandom_range(0, 99);
         if (pick < 3) begin
            send_request(OP_UNUSED, handle);
         end else if (pick < 15) begin
            send_request(OP_TRY, handle);
         end else if (pick < 15 + alloc_pct * 85 / 100) begin
            send_request(OP_ALLOC, handle);
         end else begin
            // Mostly release a handle that is really held; otherwise any handle.
            found = 1'b0;
            if ($urandom_range(0, 3) != 0) begin
               first = $urandom_range(0, SLOTS - 1);
               for (int unsigned i = 0; i < SLOTS && !found; i++) begin
                  cand = HANDLE_W'(first + i);
                  if (handle_held[cand]) begin
                     handle = cand;
                     found  = 1'b1;
                  end
               end
            end
            send_request(OP_RELEASE, handle);
         end
      end
      max_gap = 7;
   endtask

   task automatic test_pool_exhaustion;
      while (!(minted_count == MINT_LIMIT && released_fifo.size() == 0))
         send_request(OP_ALLOC, HANDLE_W'($urandom_range(0, SLOTS - 1)));
      send_request(OP_ALLOC, 8'h00);
      send_request(OP_ALLOC, 8'hFF);
      send_request(OP_TRY, 8'h00);
      send_request(OP_RELEASE, 8'hFF);
      send_request(OP_RELEASE, 8'h00);
      send_request(OP_RELEASE, 8'h80);
      send_request(OP_ALLOC, 8'h00);
      send_request(OP_TRY, 8'h00);
      send_request(OP_ALLOC, 8'h00);
      send_request(OP_ALLOC, 8'h00);
      send_request(OP_RELEASE, 8'hFF);
      send_request(OP_RELEASE, 8'hFF);
      send_request(OP_TRY, 8'h00);
      send_request(OP_TRY, 8'h00);
   endtask

   always @(posedge clock) begin
      pool_response_type exp;
      if (!reset && rsp_valid) begin
         if (awaited_responses.size() == 0) begin
            $error("unexpected response: granted_handle %0d, status %0d",
                   rsp_granted_handle, rsp_status);
            fail_count++;
         end else begin
            exp = awaited_responses.pop_front();
            if (rsp_granted_handle !== exp.granted) begin
               $error("granted_handle: expected %0d, actual %0d",
                      exp.granted, rsp_granted_handle);
               fail_count++;
            end
            if (rsp_status !== exp.status) begin
               $error("status: expected %0d (%s), actual %0d",
                      exp.status, exp.status.name(), rsp_status);
               fail_count++;
            end
            status_seen[exp.status]++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no request or response for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_op     = '0;
      req_handle = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_mixed_traffic(600);
      test_pool_exhaustion();
      test_mixed_traffic(850);

      start <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (awaited_responses.size() != 0) fail_count++;

      $display("Sent %0d requests; %0d handles minted; responses: %0d ok, %0d none free,",
               sent_count, minted_count, status_seen[STAT_OK], status_seen[STAT_NONE]);
      $display("  %0d invalid releases, %0d pool exhausted.",
               status_seen[STAT_INVALID], status_seen[STAT_EXHAUSTED]);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== fifo_handle_pool_allocator_top.f =====
rtl/core/hpa_pkg.sv
rtl/core/hpa_ram.sv
rtl/core/hpa_ctrl.sv
rtl/core/fifo_handle_pool_allocator_top.sv
sim/fifo_handle_pool_allocator_top_tb.sv
